@@ rtl/rcv_pkg.sv @@
`timescale 1ns / 1ps

package rcv_pkg;

	localparam int STRIDE_W = 13;
	localparam int REC_W    = 32;
	localparam int CRC_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_STRIDE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORDS_HELD   = 1'd1;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;
	localparam logic [CRC_W-1:0]    CRC_POLY     = 32'h82F63B78;
	localparam logic [CRC_W-1:0]    CRC_INIT     = 32'hFFFFFFFF;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic             first_of_read;
		logic [REC_W-1:0] start_record;
		logic [REC_W-1:0] records_wanted;
	} in_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} in_stage_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] payload_stride;
		logic [REC_W-1:0]    records_held;
	} cfg_t;

	function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/rcv_in_if.sv @@
`timescale 1ns / 1ps

interface rcv_in_if;
	import rcv_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       frame_byte;
	logic             first_of_read;
	logic [REC_W-1:0] start_record;
	logic [REC_W-1:0] records_wanted;

	modport source (output valid, output frame_byte, output first_of_read,
		output start_record, output records_wanted, input ready);
	modport sink (input valid, input frame_byte, input first_of_read,
		input start_record, input records_wanted, output ready);
endinterface

@@ rtl/rcv_out_if.sv @@
`timescale 1ns / 1ps

interface rcv_out_if;
	import rcv_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       out_byte;
	logic             payload_valid;
	logic             record_done;
	logic             crc_ok;
	logic [REC_W-1:0] record_number;
	logic             poisoned;
	logic [REC_W-1:0] corrupt_index;

	modport source (output valid, output out_byte, output payload_valid,
		output record_done, output crc_ok, output record_number, output poisoned,
		output corrupt_index, input ready);
	modport sink (input valid, input out_byte, input payload_valid,
		input record_done, input crc_ok, input record_number, input poisoned,
		input corrupt_index, output ready);
endinterface

@@ rtl/rcv_cfg_regs.sv @@
`timescale 1ns / 1ps

module rcv_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcv_pkg::CFG_DATA_W-1:0]   cfg_data,
	output rcv_pkg::cfg_t                    cfg
);
	import rcv_pkg::*;

	logic [STRIDE_W-1:0] stride_q;
	logic [REC_W-1:0]    held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			held_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAYLOAD_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				REG_RECORDS_HELD:   held_q   <= cfg_data[REC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.payload_stride = stride_q;
	assign cfg.records_held   = held_q;
endmodule

@@ rtl/rcv_in_reg.sv @@
`timescale 1ns / 1ps

module rcv_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	rcv_in_if.sink             frames,
	input  logic               take,
	output rcv_pkg::in_stage_t stage
);
	import rcv_pkg::*;

	logic     v_s1;
	in_item_t item_s1;

	assign frames.ready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (frames.ready) begin
			v_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			item_s1.frame_byte     <= frames.frame_byte;
			item_s1.first_of_read  <= frames.first_of_read;
			item_s1.start_record   <= frames.start_record;
			item_s1.records_wanted <= frames.records_wanted;
		end
	end

	assign stage.valid = v_s1;
	assign stage.item  = item_s1;
endmodule

@@ rtl/rcv_frame_check.sv @@
`timescale 1ns / 1ps

module rcv_frame_check #(
	parameter int MAX_STRIDE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rcv_pkg::cfg_t      cfg,
	input  rcv_pkg::in_stage_t stage,
	output logic               take,
	rcv_out_if.source          verdicts
);
	import rcv_pkg::*;

	localparam int PW = $clog2(MAX_STRIDE + 4);
	localparam int CW = (PW > STRIDE_W) ? PW : STRIDE_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_STRIDE);
	localparam logic [PW-1:0] T_LAST = PW'(3);
	localparam logic [PW-1:0] T_END  = PW'(4);

	logic [PW-1:0]    pos_q;
	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] trailer_q;
	logic [REC_W-1:0] cur_q;
	logic [REC_W-1:0] left_q;
	logic             corrupt_q;
	logic [REC_W-1:0] corrupt_idx_q;

	logic             out_v_q;
	logic [7:0]       byte_q;
	logic             pv_q, done_q, ok_q;
	logic [REC_W-1:0] recno_q;

	logic [CW-1:0]    stride_ext;
	logic [PW-1:0]    stride;
	logic [REC_W:0]   avail;
	logic [REC_W-1:0] left_new;
	logic [PW-1:0]    pos0, pos1, t;
	logic [CRC_W-1:0] crc0, crc1, tr0, tr1;
	logic [REC_W-1:0] cur0, cur1, left0, left1;
	logic             active, pv, done, ok, corrupt1;
	logic [REC_W-1:0] corrupt_idx1;
	in_item_t         it;

	assign it   = stage.item;
	assign take = stage.valid && (!out_v_q || verdicts.ready);

	always_comb begin
		stride_ext = CW'(cfg.payload_stride);
		if (stride_ext == '0) begin
			stride = PW'(1);
		end else if (stride_ext > MAX_C) begin
			stride = PW'(MAX_STRIDE);
		end else begin
			stride = stride_ext[PW-1:0];
		end
	end

	always_comb begin
		avail = {1'b0, cfg.records_held} - {1'b0, it.start_record};
		if (corrupt_q || it.records_wanted == '0 || avail[REC_W]
				|| avail[REC_W-1:0] == '0) begin
			left_new = '0;
		end else if (avail[REC_W-1:0] < it.records_wanted) begin
			left_new = avail[REC_W-1:0];
		end else begin
			left_new = it.records_wanted;
		end
	end

	always_comb begin
		if (it.first_of_read) begin
			pos0  = '0;
			crc0  = CRC_INIT;
			tr0   = '0;
			cur0  = it.start_record;
			left0 = left_new;
		end else begin
			pos0  = pos_q;
			crc0  = crc_q;
			tr0   = trailer_q;
			cur0  = cur_q;
			left0 = left_q;
		end
		active       = !corrupt_q && left0 != '0;
		t            = pos0 - stride;
		pos1         = pos0;
		crc1         = crc0;
		tr1          = tr0;
		cur1         = cur0;
		left1        = left0;
		pv           = 1'b0;
		done         = 1'b0;
		ok           = 1'b0;
		corrupt1     = corrupt_q;
		corrupt_idx1 = corrupt_idx_q;
		if (active) begin
			if (pos0 < stride) begin
				pv   = 1'b1;
				crc1 = crc32c_byte(crc0, it.frame_byte);
				pos1 = PW'(pos0 + 1'b1);
			end else begin
				if (t < T_END) begin
					tr1 = tr0 | ({24'd0, it.frame_byte} << {t[1:0], 3'b000});
				end
				if (t >= T_LAST) begin
					done = 1'b1;
					ok   = (tr1 == ~crc0);
					if (!ok) begin
						corrupt1     = 1'b1;
						corrupt_idx1 = cur0;
					end
					left1 = left0 - 1'b1;
					cur1  = cur0 + 1'b1;
					pos1  = '0;
					crc1  = CRC_INIT;
					tr1   = '0;
				end else begin
					pos1 = PW'(pos0 + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			crc_q         <= CRC_INIT;
			trailer_q     <= '0;
			cur_q         <= '0;
			left_q        <= '0;
			corrupt_q     <= 1'b0;
			corrupt_idx_q <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (take) begin
				pos_q         <= pos1;
				crc_q         <= crc1;
				trailer_q     <= tr1;
				cur_q         <= cur1;
				left_q        <= left1;
				corrupt_q     <= corrupt1;
				corrupt_idx_q <= corrupt_idx1;
				out_v_q       <= 1'b1;
			end else if (verdicts.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q  <= it.frame_byte;
			pv_q    <= pv;
			done_q  <= done;
			ok_q    <= ok;
			recno_q <= cur0;
		end
	end

	assign verdicts.valid         = out_v_q;
	assign verdicts.out_byte      = byte_q;
	assign verdicts.payload_valid = pv_q;
	assign verdicts.record_done   = done_q;
	assign verdicts.crc_ok        = ok_q;
	assign verdicts.record_number = recno_q;
	assign verdicts.poisoned      = corrupt_q;
	assign verdicts.corrupt_index = corrupt_q ? corrupt_idx_q : '0;
endmodule

@@ rtl/record_crc_verifier.sv @@
`timescale 1ns / 1ps
// Path: an accepted beat goes into the input register, then into the result
//   register, where it stays until the sink takes it.
// Throughput: one beat per cycle unless the sink stalls; the byte-wide CRC32C
//   update sits between the two registers, so nothing iterates.
// Reset (arst_n low, async): stride 64, records_held 0, no read active,
//   CRC all ones, poison flag clear, both pipeline registers empty.

module record_crc_verifier #(
	parameter int MAX_STRIDE = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcv_in_if.sink                         frames,
	rcv_out_if.source                      verdicts,
	input  logic                           cfg_we,
	input  logic [rcv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcv_pkg::*;

	cfg_t      cfg;
	in_stage_t stage;
	logic      take;

	rcv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rcv_in_reg u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.frames (frames),
		.take   (take),
		.stage  (stage)
	);

	rcv_frame_check #(
		.MAX_STRIDE (MAX_STRIDE)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.stage    (stage),
		.take     (take),
		.verdicts (verdicts)
	);

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		verdicts.valid |-> !(verdicts.payload_valid && verdicts.record_done))
		else $error("payload and record end flagged on one beat");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		verdicts.valid && verdicts.crc_ok |-> verdicts.record_done)
		else $error("crc_ok without record end");

	a_bad_poisons: assert property (@(posedge clk) disable iff (!arst_n)
		verdicts.valid && verdicts.record_done && !verdicts.crc_ok |-> verdicts.poisoned)
		else $error("mismatch did not poison");

	a_poison_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		verdicts.poisoned |=> verdicts.poisoned)
		else $error("poison flag cleared");
`endif
endmodule

@@ tb/record_verdict_checker.sv @@
`timescale 1ns / 1ps

module record_verdict_checker #(
	parameter int MAX_STRIDE = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcv_in_if                              frames,
	rcv_out_if                             verdicts,
	input  logic                           cfg_we,
	input  logic [rcv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcv_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import rcv_pkg::*;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             payload_valid;
		logic             record_done;
		logic             crc_ok;
		logic [REC_W-1:0] record_number;
		logic             poisoned;
		logic [REC_W-1:0] corrupt_index;
	} verdict_t;

	verdict_t expected_verdicts[$];

	logic [STRIDE_W-1:0] stride_reg;
	logic [REC_W-1:0]    held_reg;
	int unsigned         pos;
	logic [CRC_W-1:0]    crc;
	logic [CRC_W-1:0]    trailer;
	logic [REC_W-1:0]    cur_rec;
	logic [REC_W-1:0]    recs_left;
	logic                healthy;
	logic                corrupt;
	logic [REC_W-1:0]    bad_rec;

	function automatic logic [CRC_W-1:0] crc32c_step(input logic [CRC_W-1:0] c,
			input logic [7:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ CRC_W'(b);
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
		return r;
	endfunction

	function automatic verdict_t judge_byte(input in_item_t it);
		verdict_t    v;
		int unsigned span;
		int unsigned lane;
		logic [REC_W-1:0] avail;
		span = (stride_reg == 0) ? 1 :
			(stride_reg > MAX_STRIDE) ? MAX_STRIDE : int'(stride_reg);
		v = '0;
		if (it.first_of_read) begin
			pos = 0;
			crc = '1;
			trailer = '0;
			cur_rec = it.start_record;
			if (!healthy || it.records_wanted == 0 || it.start_record >= held_reg) begin
				recs_left = '0;
			end else begin
				avail = held_reg - it.start_record;
				recs_left = (avail < it.records_wanted) ? avail : it.records_wanted;
			end
		end
		v.record_number = cur_rec;
		if (healthy && recs_left != 0) begin
			if (pos < span) begin
				v.payload_valid = 1'b1;
				crc = crc32c_step(crc, it.frame_byte);
				pos++;
			end else begin
				lane = pos - span;
				if (lane < 4)
					trailer |= CRC_W'(it.frame_byte) << (8 * lane);
				if (lane >= 3) begin
					v.record_done = 1'b1;
					v.crc_ok = (trailer == ~crc);
					if (!v.crc_ok) begin
						corrupt = 1'b1;
						bad_rec = cur_rec;
						healthy = 1'b0;
					end
					recs_left--;
					cur_rec++;
					pos = 0;
					crc = '1;
					trailer = '0;
				end else begin
					pos++;
				end
			end
		end
		v.out_byte = it.frame_byte;
		v.poisoned = corrupt;
		v.corrupt_index = corrupt ? bad_rec : '0;
		return v;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		in_item_t it;
		if (!arst_n) begin
			expected_verdicts.delete();
			stride_reg = STRIDE_RESET;
			held_reg = '0;
			pos = 0;
			crc = '1;
			trailer = '0;
			cur_rec = '0;
			recs_left = '0;
			healthy = 1'b1;
			corrupt = 1'b0;
			bad_rec = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (verdicts.valid && verdicts.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict beat with nothing expected: byte %0h", verdicts.out_byte);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("out_byte", 32'(want.out_byte), 32'(verdicts.out_byte));
					check_field("payload_valid", 32'(want.payload_valid),
						32'(verdicts.payload_valid));
					check_field("record_done", 32'(want.record_done),
						32'(verdicts.record_done));
					check_field("crc_ok", 32'(want.crc_ok), 32'(verdicts.crc_ok));
					check_field("record_number", want.record_number, verdicts.record_number);
					check_field("poisoned", 32'(want.poisoned), 32'(verdicts.poisoned));
					check_field("corrupt_index", want.corrupt_index, verdicts.corrupt_index);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PAYLOAD_STRIDE: stride_reg = cfg_data[STRIDE_W-1:0];
					REG_RECORDS_HELD:   held_reg = cfg_data[REC_W-1:0];
					default: ;
				endcase
			end
			if (frames.valid && frames.ready) begin
				it.frame_byte = frames.frame_byte;
				it.first_of_read = frames.first_of_read;
				it.start_record = frames.start_record;
				it.records_wanted = frames.records_wanted;
				expected_verdicts.push_back(judge_byte(it));
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rcv_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  steady = 1'b0;
	int                    holds_asked = 0;
	int                    wanted_bytes = 0;
	int                    errors;
	int                    pending;

	rcv_in_if  frames();
	rcv_out_if verdicts();

	record_crc_verifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frames   (frames),
		.verdicts (verdicts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	record_verdict_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.frames   (frames),
		.verdicts (verdicts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [31:0] crc32c_feed(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ 32'(b);
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
		return r;
	endfunction

	task automatic offer_byte(input logic [7:0] b, input logic first, input logic [31:0] start,
			input logic [31:0] wanted);
		if (!steady) begin
			while ($urandom_range(99) < 27) begin
				frames.valid <= 1'b0;
				@(posedge clk);
			end
		end
		frames.valid <= 1'b1;
		frames.frame_byte <= b;
		frames.first_of_read <= first;
		frames.start_record <= start;
		frames.records_wanted <= wanted;
		do @(posedge clk); while (!frames.ready);
	endtask

	// upto < span + 4 cuts the frame short
	task automatic send_frame(input int unsigned span, input logic opens,
			input logic [31:0] start, input logic [31:0] wanted, input logic spoil,
			input int unsigned upto);
		logic [31:0] c;
		logic [7:0]  b;
		c = '1;
		for (int unsigned i = 0; i < upto; i++) begin
			if (i < span) begin
				b = 8'($urandom());
				c = crc32c_feed(c, b);
			end else begin
				b = 8'(~c >> (8 * (i - span)));
				if (spoil && i == span)
					b = ~b;
			end
			if (opens && i == 0)
				offer_byte(b, 1'b1, start, wanted);
			else
				offer_byte(b, 1'b0, $urandom(), $urandom());
			wanted_bytes++;
		end
	endtask

	task automatic settle();
		frames.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [STRIDE_W-1:0] stride, input logic [31:0] held);
		cfg_we <= 1'b1;
		cfg_index <= REG_PAYLOAD_STRIDE;
		cfg_data <= ($urandom() << STRIDE_W) | CFG_DATA_W'(stride);
		@(posedge clk);
		cfg_index <= REG_RECORDS_HELD;
		cfg_data <= held;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : sink_side
		int hold_left;
		int holds_taken;
		hold_left = 0;
		holds_taken = 0;
		verdicts.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				verdicts.ready <= 1'b0;
			end else if (holds_taken != holds_asked) begin
				holds_taken++;
				hold_left = 400;
				verdicts.ready <= 1'b0;
			end else begin
				verdicts.ready <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	initial begin : stimulus
		logic [31:0]  c;
		logic [31:0]  start;
		logic [31:0]  wanted;
		logic [31:0]  held;
		logic [31:0]  count;
		logic [7:0]   pay [4];
		logic [12:0]  stride;
		int unsigned  span;
		int unsigned  nrec;
		int unsigned  upto;
		int           phase;
		int           r;
		int           base;
		int           guard;
		frames.valid = 1'b0;
		frames.frame_byte = '0;
		frames.first_of_read = 1'b0;
		frames.start_record = '0;
		frames.records_wanted = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: empty log, so no record is read
		offer_byte(8'h00, 1'b1, 32'd0, 32'd1);
		offer_byte(8'hFF, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		settle();
		set_regs(13'd1, 32'd16);
		send_frame(1, 1'b1, 32'd0, 32'hFFFFFFFF, 1'b0, 5);
		send_frame(1, 1'b0, 32'd0, 32'd0, 1'b0, 5);
		offer_byte(8'h5A, 1'b1, 32'hFFFFFFFF, 32'd3);
		offer_byte(8'hA5, 1'b0, 32'd0, 32'd0);
		offer_byte(8'h3C, 1'b1, 32'd2, 32'd0);
		offer_byte(8'hC3, 1'b0, 32'd7, 32'd7);
		// request clamped to the one record left
		send_frame(1, 1'b1, 32'd15, 32'd5, 1'b0, 5);
		offer_byte(8'h00, 1'b0, 32'd0, 32'd0);
		offer_byte(8'hFF, 1'b0, 32'd0, 32'd0);

		// stride shrinks to exactly the current position
		settle();
		set_regs(13'd8, 32'd16);
		c = '1;
		for (int i = 0; i < 3; i++) begin
			pay[i] = 8'($urandom());
			c = crc32c_feed(c, pay[i]);
			offer_byte(pay[i], i == 0, 32'd3, 32'd2);
		end
		settle();
		set_regs(13'd3, 32'd16);
		for (int i = 0; i < 4; i++)
			offer_byte(8'(~c >> (8 * i)), 1'b0, $urandom(), $urandom());

		// stride shrinks past the trailer: frame ends on the next beat
		settle();
		set_regs(13'd4, 32'd16);
		do begin
			c = '1;
			for (int i = 0; i < 4; i++) begin
				pay[i] = 8'($urandom());
				c = crc32c_feed(c, pay[i]);
			end
		end while (c[31:24] != 8'hFF);
		for (int i = 0; i < 4; i++)
			offer_byte(pay[i], 1'b0, $urandom(), $urandom());
		for (int i = 0; i < 3; i++)
			offer_byte(8'(~c >> (8 * i)), 1'b0, $urandom(), $urandom());
		settle();
		set_regs(13'd2, 32'd0);
		offer_byte(8'($urandom()), 1'b0, $urandom(), $urandom());
		offer_byte(8'($urandom()), 1'b0, $urandom(), $urandom());

		// widest stride (clamped), and a zero stride
		settle();
		set_regs(13'd8191, 32'd3);
		send_frame(4096, 1'b1, 32'd0, 32'd3, 1'b0, 4100);
		settle();
		set_regs(13'd0, 32'd3);
		send_frame(1, 1'b0, 32'd0, 32'd0, 1'b0, 5);

		base = wanted_bytes;
		for (phase = 0; phase < 4 || wanted_bytes - base < 2000; phase++) begin
			settle();
			case (phase % 4)
				0: stride = 13'($urandom_range(1, 6));
				1: stride = 13'($urandom_range(7, 40));
				2: stride = 13'($urandom_range(0, 1));
				default: stride = 13'($urandom_range(1, 16));
			endcase
			held = phase[0] ? ($urandom() | 32'd1) : 32'($urandom_range(4, 20));
			span = (stride == 0) ? 1 : stride;
			set_regs(stride, held);
			steady <= (phase == 3);
			if (phase == 2)
				holds_asked <= holds_asked + 1;
			repeat (30) begin
				r = $urandom_range(99);
				if (r < 80) begin
					start = $urandom_range(0, held - 1);
					wanted = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 4);
					count = held - start;
					if (wanted < count)
						count = wanted;
					nrec = $urandom_range(1, 3);
					if (nrec > count)
						nrec = count;
					for (int j = 0; j < nrec; j++) begin
						upto = ($urandom_range(19) == 0) ? $urandom_range(1, span + 3) : span + 4;
						send_frame(span, j == 0, start, wanted, 1'b0, upto);
						if (upto != span + 4)
							break;
					end
					if (upto == span + 4 && $urandom_range(3) == 0)
						offer_byte(8'($urandom()), 1'b0, $urandom(), $urandom());
				end else begin
					// reads that get no records
					if (r < 90 && held != '1)
						offer_byte(8'($urandom()), 1'b1, $urandom_range(held, 32'hFFFFFFFF),
							$urandom());
					else
						offer_byte(8'($urandom()), 1'b1, $urandom(), 32'd0);
					repeat ($urandom_range(0, 3))
						offer_byte(8'($urandom()), 1'b0, $urandom(), $urandom());
				end
			end
		end

		// corrupt record: poisons the block for the rest of the run
		settle();
		steady <= 1'b0;
		set_regs(13'd2, 32'hFFFFFFFF);
		send_frame(2, 1'b1, 32'hFFFFFFF0, 32'd5, 1'b0, 6);
		send_frame(2, 1'b0, 32'd0, 32'd0, 1'b1, 6);
		send_frame(2, 1'b0, 32'd0, 32'd0, 1'b0, 6);
		offer_byte(8'($urandom()), 1'b1, 32'd0, 32'd1);
		repeat (6)
			offer_byte(8'($urandom()), 1'b0, $urandom(), $urandom());

		frames.valid <= 1'b0;
		for (guard = 0; guard < 10000 && pending != 0; guard++)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
